FILE: hdl/wart_pkg.sv
// ----------------------------------------------------------------------------
// Weekly alarm relay timer package
// Shared types and constants for the alarm cell chain and its controller.
// ----------------------------------------------------------------------------
package wart_pkg;

    localparam int IDX_W  = 4;
    localparam int DAYS_W = 8;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int DOW_W  = 3;
    localparam int DUR_W  = 7;
    localparam int CNT_W  = 5;

    localparam logic [3:0] DAY_BIT_BASE = 4'd8;

    localparam logic [1:0] REG_ALARM_ENABLE = 2'd0;
    localparam logic [1:0] REG_PROGRAM_MODE = 2'd1;
    localparam logic [1:0] REG_ALARM_COUNT  = 2'd2;

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [DUR_W-1:0]  duration;
    } slot_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] index;
        slot_t            slot;
    } slot_wr_t;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [IDX_W-1:0]  hit_index;
        logic [DUR_W-1:0]  hit_duration;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [DAYS_W-1:0] day_sel;
    } probe_t;

endpackage

FILE: hdl/weekly_alarm_relay_timer_top.sv
// ----------------------------------------------------------------------------
// Weekly alarm relay timer
// Weekly alarm table with countdown or direct relay switching on minute change.
// ----------------------------------------------------------------------------
// Each alarm slot lives in its own cell; a tick sends a probe down the row of
// ALARM_SLOTS cells, one cell per cycle, and the first matching cell marks it.
// A tick transaction holds off the next input while the probe walks the cell
// row and until its result is registered; a table write skips the walk but
// likewise waits for the output register. One item is worked on at a time.
// The result sits in an output register, so a new item is accepted while the
// previous result still waits. Table slots have no reset and must be written
// before alarm_count covers them.
module weekly_alarm_relay_timer_top #(
    parameter int ALARM_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [4:0]  cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: now_hour[4:0], now_minute[10:5], now_dow[13:11], entry_index[17:14],
    //        entry_days[25:18], entry_hour[30:26], entry_minute[36:31],
    //        entry_duration[43:37], zero fill[47:44]
    input  logic [47:0] s_tdata,
    // tuser: op[0]
    input  logic        s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: relay_level[0], led_level[1], beep[2], remaining[9:3], matched[10],
    //        match_index[14:11], zero fill[15]
    output logic [15:0] m_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic                       alarm_enable_reg;
    logic                       program_mode_reg;
    logic [wart_pkg::CNT_W-1:0] alarm_count_reg;

    logic [wart_pkg::DUR_W-1:0] remaining_reg;
    logic [wart_pkg::MIN_W-1:0] last_minute_reg;
    logic                       relay_reg;
    logic                       led_reg;

    logic                       beep_reg;
    logic                       matched_reg;
    logic [wart_pkg::IDX_W-1:0] match_index_reg;

    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;

    logic                        in_accept;
    logic                        out_free;
    logic [wart_pkg::HOUR_W-1:0] in_hour;
    logic [wart_pkg::MIN_W-1:0]  in_minute;
    logic [wart_pkg::DOW_W-1:0]  in_dow;
    logic                        scan_on;
    logic [wart_pkg::DAYS_W-1:0] day_sel;

    wart_pkg::slot_wr_t slot_wr;
    wart_pkg::probe_t   probe_head;
    wart_pkg::probe_t   chain [0:ALARM_SLOTS];
    wart_pkg::probe_t   probe_end;

    logic [wart_pkg::DUR_W-1:0] rem_base;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign in_hour   = s_tdata[4:0];
    assign in_minute = s_tdata[10:5];
    assign in_dow    = s_tdata[13:11];

    assign scan_on = (in_minute != last_minute_reg) && alarm_enable_reg;

    always_comb begin
        if (!scan_on || (in_dow == '0)) begin
            day_sel = '0;
        end else begin
            day_sel = 8'd1 << (wart_pkg::DAY_BIT_BASE - {1'b0, in_dow});
        end
    end

    always_comb begin
        slot_wr.en            = in_accept && s_tuser;
        slot_wr.index         = s_tdata[17:14];
        slot_wr.slot.days     = s_tdata[25:18];
        slot_wr.slot.hour     = s_tdata[30:26];
        slot_wr.slot.minute   = s_tdata[36:31];
        slot_wr.slot.duration = s_tdata[43:37];
    end

    always_comb begin
        probe_head            = '0;
        probe_head.valid      = in_accept && !s_tuser;
        probe_head.hour       = in_hour;
        probe_head.minute     = in_minute;
        probe_head.day_sel    = day_sel;
    end

    assign chain[0] = probe_head;

    for (genvar k = 0; k < ALARM_SLOTS; k++) begin : g_cell
        wart_cell #(
            .SLOT_ID(k)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .wr         (slot_wr),
            .alarm_count(alarm_count_reg),
            .probe_in   (chain[k]),
            .probe_out  (chain[k+1])
        );
    end

    assign probe_end = chain[ALARM_SLOTS];

    assign rem_base = (probe_end.hit && !program_mode_reg) ? probe_end.hit_duration
                                                           : remaining_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = s_tuser ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (probe_end.valid) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_enable_reg <= 1'b0;
            program_mode_reg <= 1'b0;
            alarm_count_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                wart_pkg::REG_ALARM_ENABLE: alarm_enable_reg <= cfg_wdata[0];
                wart_pkg::REG_PROGRAM_MODE: program_mode_reg <= cfg_wdata[0];
                wart_pkg::REG_ALARM_COUNT:  alarm_count_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            remaining_reg   <= '0;
            last_minute_reg <= '0;
            relay_reg       <= 1'b0;
            led_reg         <= 1'b0;
            beep_reg        <= 1'b0;
            matched_reg     <= 1'b0;
            match_index_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        beep_reg        <= 1'b0;
                        matched_reg     <= 1'b0;
                        match_index_reg <= '0;
                        if (!s_tuser) begin
                            last_minute_reg <= in_minute;
                        end
                    end
                end
                ST_SCAN: begin
                    if (probe_end.valid) begin
                        matched_reg     <= probe_end.hit;
                        match_index_reg <= probe_end.hit ? probe_end.hit_index : '0;
                        if (!program_mode_reg) begin
                            if (rem_base == '0) begin
                                relay_reg     <= 1'b1;
                                remaining_reg <= rem_base;
                            end else begin
                                relay_reg     <= 1'b0;
                                remaining_reg <= rem_base - 1'b1;
                                beep_reg      <= 1'b1;
                            end
                        end else if (probe_end.hit) begin
                            relay_reg <= (probe_end.hit_duration == '0);
                            led_reg   <= (probe_end.hit_duration != '0);
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            m_tdata_reg <= {1'b0, match_index_reg, matched_reg, remaining_reg,
                            beep_reg, led_reg, relay_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: hdl/wart_cell.sv
// ----------------------------------------------------------------------------
// Alarm cell
// Holds one alarm slot and compares the passing probe against it, handing
// the probe on to the next cell every cycle.
// ----------------------------------------------------------------------------
module wart_cell #(
    parameter int SLOT_ID = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  wart_pkg::slot_wr_t         wr,
    input  logic [wart_pkg::CNT_W-1:0] alarm_count,
    input  wart_pkg::probe_t           probe_in,
    output wart_pkg::probe_t           probe_out
);

    localparam logic [wart_pkg::IDX_W-1:0] SLOT_IDX = wart_pkg::IDX_W'(SLOT_ID);

    wart_pkg::slot_t  slot_reg;
    wart_pkg::probe_t probe_reg;
    wart_pkg::probe_t probe_next;
    logic             slot_match;

    always_comb begin
        slot_match = slot_reg.days[0]
                  && (slot_reg.hour == probe_in.hour)
                  && (slot_reg.minute == probe_in.minute)
                  && ((slot_reg.days & probe_in.day_sel) != '0)
                  && (SLOT_ID < int'(alarm_count));
        probe_next = probe_in;
        if (probe_in.valid && !probe_in.hit && slot_match) begin
            probe_next.hit          = 1'b1;
            probe_next.hit_index    = SLOT_IDX;
            probe_next.hit_duration = slot_reg.duration;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en && (int'(wr.index) == SLOT_ID)) begin
            slot_reg <= wr.slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg <= '0;
        end else begin
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;

endmodule

FILE: hdl/wart_checker.sv
// ----------------------------------------------------------------------------
// Weekly alarm relay timer checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module wart_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_reset_clears_valid: assert property (
        @(posedge aclk) !aresetn |=> !m_tvalid
    ) else $error("result valid after reset");

    a_valid_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid
    ) else $error("result valid dropped while stalled");

    a_beep_relay_low: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> !m_tdata[0]
    ) else $error("beep with relay high");

    a_no_match_zero_index: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[10]) |-> (m_tdata[14:11] == 4'd0)
    ) else $error("match index set without a match");

endmodule

bind weekly_alarm_relay_timer_top wart_checker u_wart_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
